[rtl/qvr_pkg.sv]
// qvr_pkg: operation codes and the Hamilton product term table for the
// quaternion product and vector rotate unit. No dependencies.

package qvr_pkg;

	typedef enum logic [1:0] {
		OP_PRODUCT = 2'd0,
		OP_ROTATE  = 2'd1,
		OP_CONJ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// one product term: a index, b index, subtract flag (x, y, z, w order)
	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic       neg;
	} term_t;

	localparam term_t TERM_TAB [4][4] = '{
		'{'{2'd3, 2'd0, 1'b0}, '{2'd0, 2'd3, 1'b0}, '{2'd1, 2'd2, 1'b0}, '{2'd2, 2'd1, 1'b1}},
		'{'{2'd3, 2'd1, 1'b0}, '{2'd0, 2'd2, 1'b1}, '{2'd1, 2'd3, 1'b0}, '{2'd2, 2'd0, 1'b0}},
		'{'{2'd3, 2'd2, 1'b0}, '{2'd0, 2'd1, 1'b0}, '{2'd1, 2'd0, 1'b1}, '{2'd2, 2'd3, 1'b0}},
		'{'{2'd3, 2'd3, 1'b0}, '{2'd0, 2'd0, 1'b1}, '{2'd1, 2'd1, 1'b1}, '{2'd2, 2'd2, 1'b1}}
	};

endpackage

[rtl/qvr_qmul.sv]
// qvr_qmul: four-stage pipelined Hamilton product with floor shift and
// saturation. Stages: multiply, pair add, final add, shift/saturate.
// Depends on qvr_pkg (term table).

module qvr_qmul #(
	parameter int AW   = 32,
	parameter int BW   = 32,
	parameter int OW   = 32,
	parameter int FRAC = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a [4],
	input  logic signed [BW-1:0] b [4],
	output logic signed [OW-1:0] r [4]
);
	import qvr_pkg::*;

	localparam int PW = AW + BW;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] MAXV = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-OW+1){1'b1}}, {(OW-1){1'b0}}};

	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [SW-1:0] term   [4][4];
	logic signed [SW-1:0] pair_s2 [4][2];
	logic signed [SW-1:0] sum_s3 [4];
	logic signed [SW-1:0] shf    [4];
	logic signed [OW-1:0] r_s4   [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int t = 0; t < 4; t++) begin
					prod_s1[c][t] <= a[TERM_TAB[c][t].ia] * b[TERM_TAB[c][t].ib];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int t = 0; t < 4; t++) begin
				term[c][t] = {{2{prod_s1[c][t][PW-1]}}, prod_s1[c][t]};
				if (TERM_TAB[c][t].neg)
					term[c][t] = -term[c][t];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				pair_s2[c][0] <= term[c][0] + term[c][1];
				pair_s2[c][1] <= term[c][2] + term[c][3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				sum_s3[c] <= pair_s2[c][0] + pair_s2[c][1];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			shf[c] = sum_s3[c] >>> FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				if (shf[c] > MAXV)
					r_s4[c] <= MAXV[OW-1:0];
				else if (shf[c] < MINV)
					r_s4[c] <= MINV[OW-1:0];
				else
					r_s4[c] <= shf[c][OW-1:0];
			end
		end
	end

	assign r = r_s4;

endmodule

[rtl/quaternion_product_and_vector_rotate.sv]
// Quaternion product, vector rotate and conjugate, signed fixed point.
// Two chained qvr_qmul pipelines plus delay lines; depends on qvr_pkg.
//
//  channel | signals                                   | dir
//  in      | in_valid, in_stall, req_type, a_*, b_*    | beat in
//  out     | out_valid, out_stall, r_x, r_y, r_z, r_w  | beat out
//
// Every operation runs the full pipeline depth; one beat enters per cycle while the pipeline is not held.
// The two 4-stage multiply pipelines in series set the depth.
// The whole pipeline holds while the last stage is valid and stalled.
// Reset clears only the stage valid bits.

module quaternion_product_and_vector_rotate #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] a_x,
	input  logic signed [DATA_WIDTH-1:0] a_y,
	input  logic signed [DATA_WIDTH-1:0] a_z,
	input  logic signed [DATA_WIDTH-1:0] a_w,
	input  logic signed [DATA_WIDTH-1:0] b_x,
	input  logic signed [DATA_WIDTH-1:0] b_y,
	input  logic signed [DATA_WIDTH-1:0] b_z,
	input  logic signed [DATA_WIDTH-1:0] b_w,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] r_x,
	output logic signed [DATA_WIDTH-1:0] r_y,
	output logic signed [DATA_WIDTH-1:0] r_z,
	output logic signed [DATA_WIDTH-1:0] r_w
);
	import qvr_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

	logic                 advance;
	logic [9:1]           vld_s;
	op_t                  op_s  [1:8];
	logic signed [DW-1:0] a_s   [1:8][4];
	logic signed [DW-1:0] r1_s  [5:8][4];
	logic signed [DW-1:0] qa    [4];
	logic signed [DW-1:0] qb    [4];
	logic signed [DW-1:0] r1    [4];
	logic signed [DW:0]   cj    [4];
	logic signed [DW-1:0] r2    [4];
	logic signed [DW-1:0] res   [4];
	logic signed [DW-1:0] r_s9  [4];

	assign advance  = !(vld_s[9] && out_stall);
	assign in_stall = !advance;
	assign out_valid = vld_s[9];

	assign qa[0] = a_x;
	assign qa[1] = a_y;
	assign qa[2] = a_z;
	assign qa[3] = a_w;
	assign qb[0] = b_x;
	assign qb[1] = b_y;
	assign qb[2] = b_z;
	assign qb[3] = (op_t'(req_type) == OP_ROTATE) ? '0 : b_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[8:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s[1] <= op_t'(req_type);
			a_s[1]  <= qa;
			for (int s = 2; s <= 8; s++) begin
				op_s[s] <= op_s[s-1];
				a_s[s]  <= a_s[s-1];
			end
			r1_s[5] <= r1;
			for (int s = 6; s <= 8; s++) begin
				r1_s[s] <= r1_s[s-1];
			end
			r_s9 <= res;
		end
	end

	qvr_qmul #(
		.AW   (DW),
		.BW   (DW),
		.OW   (DW),
		.FRAC (FRAC_BITS)
	) u_mul0 (
		.clk (clk),
		.en  (advance),
		.a   (qa),
		.b   (qb),
		.r   (r1)
	);

	// exact conjugate of a for the second product
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cj[i] = -{a_s[4][i][DW-1], a_s[4][i]};
		end
		cj[3] = {a_s[4][3][DW-1], a_s[4][3]};
	end

	qvr_qmul #(
		.AW   (DW),
		.BW   (DW + 1),
		.OW   (DW),
		.FRAC (FRAC_BITS)
	) u_mul1 (
		.clk (clk),
		.en  (advance),
		.a   (r1),
		.b   (cj),
		.r   (r2)
	);

	always_comb begin
		case (op_s[8])
			OP_PRODUCT: begin
				res = r1_s[8];
			end
			OP_ROTATE: begin
				res[0] = r2[0];
				res[1] = r2[1];
				res[2] = r2[2];
				res[3] = '0;
			end
			OP_CONJ: begin
				for (int i = 0; i < 3; i++) begin
					res[i] = (a_s[8][i] == DMIN) ? DMAX : -a_s[8][i];
				end
				res[3] = a_s[8][3];
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					res[i] = '0;
				end
			end
		endcase
	end

	assign r_x = r_s9[0];
	assign r_y = r_s9[1];
	assign r_z = r_s9[2];
	assign r_w = r_s9[3];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output stage");

	a_valid_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid == $past(vld_s[8]))
		else $error("output valid does not follow pipeline");

	a_rotate_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && vld_s[8] && op_s[8] == OP_ROTATE) |=> r_w == '0)
		else $error("rotate result has nonzero scalar");

	a_conj_w_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && vld_s[8] && op_s[8] == OP_CONJ) |=> r_w == $past(a_s[8][3]))
		else $error("conjugate scalar altered");

endmodule

[tb/sv/tb_quaternion_product_and_vector_rotate.sv]
// Testbench for quaternion_product_and_vector_rotate: random and directed product, rotate, conjugate
// and no-op beats, checked against an in-bench Q16.16 predictor through a small scoreboard.
// Depends on qvr_pkg and the quaternion_product_and_vector_rotate RTL.

module tb_quaternion_product_and_vector_rotate;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	localparam int DW          = 32;
	localparam int FRAC        = 16;
	localparam int N_RANDOM    = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	localparam logic [DW-1:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] Q_MIN  = 32'h8000_0000;
	localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [DW-1:0] Q_HALF = 32'h0000_B505;

	localparam logic signed [71:0] SUM_HI = 72'sd2147483647;
	localparam logic signed [71:0] SUM_LO = -72'sd2147483648;

	typedef logic signed [33:0] wcomp_t;
	typedef logic [0:3][DW-1:0] quat_t;

	typedef struct packed {
		op_t   op;
		quat_t a;
		quat_t b;
	} request_t;

	// Q16.16 quaternion arithmetic and the queue of results still owed by the block
	class quat_scoreboard;
		quat_t expected_results[$];
		int    fail_count;

		function logic [DW-1:0] narrow_sat(input logic signed [71:0] s);
			logic signed [71:0] sh;
			sh = s >>> FRAC;
			if (sh > SUM_HI)
				return Q_MAX;
			if (sh < SUM_LO)
				return Q_MIN;
			return sh[DW-1:0];
		endfunction

		function quat_t hamilton(input wcomp_t p[4], input wcomp_t q[4]);
			logic signed [71:0] s[4];
			quat_t r;
			s[0] = p[3] * q[0] + p[0] * q[3] + p[1] * q[2] - p[2] * q[1];
			s[1] = p[3] * q[1] - p[0] * q[2] + p[1] * q[3] + p[2] * q[0];
			s[2] = p[3] * q[2] + p[0] * q[1] - p[1] * q[0] + p[2] * q[3];
			s[3] = p[3] * q[3] - p[0] * q[0] - p[1] * q[1] - p[2] * q[2];
			for (int i = 0; i < 4; i++)
				r[i] = narrow_sat(s[i]);
			return r;
		endfunction

		function logic [DW-1:0] neg_sat(input logic [DW-1:0] v);
			if (v == Q_MIN)
				return Q_MAX;
			return -v;
		endfunction

		function quat_t predict_result(input request_t req);
			wcomp_t qa[4];
			wcomp_t qb[4];
			wcomp_t qc[4];
			quat_t  t;
			quat_t  r;
			r = '0;
			for (int i = 0; i < 4; i++) begin
				qa[i] = $signed(req.a[i]);
				qb[i] = $signed(req.b[i]);
			end
			case (req.op)
				OP_PRODUCT: r = hamilton(qa, qb);
				OP_ROTATE: begin
					qb[3] = '0;
					t = hamilton(qa, qb);
					for (int i = 0; i < 4; i++)
						qb[i] = $signed(t[i]);
					for (int i = 0; i < 3; i++)
						qc[i] = -qa[i];
					qc[3] = qa[3];
					r = hamilton(qb, qc);
					r[3] = '0;
				end
				OP_CONJ: begin
					for (int i = 0; i < 3; i++)
						r[i] = neg_sat(req.a[i]);
					r[3] = req.a[3];
				end
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_request(input request_t req);
			expected_results.push_back(predict_result(req));
		endfunction

		function void check_result(input quat_t got);
			quat_t want;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			want = expected_results.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got[i] !== want[i]) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch comp %0d: expected %h actual %h (exp %h act %h)",
							i, want[i], got[i], want, got);
				end
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [1:0]      req_type;
	logic [DW-1:0]   a_x, a_y, a_z, a_w;
	logic [DW-1:0]   b_x, b_y, b_z, b_w;
	logic            out_valid;
	logic            out_stall;
	logic [DW-1:0]   r_x, r_y, r_z, r_w;

	quat_scoreboard sb = new();
	int             rx_freeze = 0;
	int             cycle_count = 0;
	int             tx_calm = 0;

	quaternion_product_and_vector_rotate #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FRAC)
	) i_dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("quaternion_product_and_vector_rotate verification failed");
			$finish;
		end
	end

	initial begin
		int   hold;
		int   calm;
		logic froze;
		hold = 0;
		calm = 0;
		froze = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result({r_x, r_y, r_z, r_w});
				if (calm > 0) begin
					calm--;
					hold = 0;
				end else begin
					hold = $urandom_range(0, 11);
					if ($urandom_range(0, 25) == 0)
						calm = $urandom_range(10, 40);
				end
			end
			if (rx_freeze > 0 && !froze) begin
				hold = rx_freeze;
				froze = 1'b1;
			end
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	function automatic logic [DW-1:0] rand_comp();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2: return $urandom;
			3, 4:    return DW'($signed($urandom_range(0, 262144)) - 131072);
			5, 6, 7: return DW'($signed($urandom_range(0, 131072)) - 65536);
			8: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return '1;
					default: return Q_ONE;
				endcase
			end
			default: return DW'($signed($urandom) >>> $urandom_range(0, 31));
		endcase
	endfunction

	function automatic request_t rand_request();
		request_t req;
		int unsigned pick;
		pick = $urandom_range(0, 31);
		if (pick == 0)
			req.op = OP_NONE;
		else
			req.op = op_t'(pick % 3);
		for (int i = 0; i < 4; i++) begin
			req.a[i] = rand_comp();
			req.b[i] = rand_comp();
		end
		return req;
	endfunction

	task automatic send_beat(input request_t req, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req.op;
		a_x <= req.a[0];
		a_y <= req.a[1];
		a_z <= req.a[2];
		a_w <= req.a[3];
		b_x <= req.b[0];
		b_y <= req.b[1];
		b_z <= req.b[2];
		b_w <= req.b[3];
		do @(posedge clk); while (in_stall);
		sb.note_request(req);
	endtask

	function automatic int draw_gap();
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		if ($urandom_range(0, 25) == 0)
			tx_calm = $urandom_range(10, 40);
		return $urandom_range(0, 11);
	endfunction

	function automatic request_t mk(input op_t op, input quat_t a, input quat_t b);
		request_t req;
		req.op = op;
		req.a  = a;
		req.b  = b;
		return req;
	endfunction

	initial begin
		request_t directed[$];
		quat_t    r1, r2;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		req_type <= OP_PRODUCT;
		{a_x, a_y, a_z, a_w} <= '0;
		{b_x, b_y, b_z, b_w} <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		r1 = {$urandom, $urandom, $urandom, $urandom};
		r2 = {$urandom, $urandom, $urandom, $urandom};
		directed.push_back(mk(OP_PRODUCT, {32'h0, 32'h0, 32'h0, Q_ONE}, r1));
		directed.push_back(mk(OP_PRODUCT, {4{Q_MAX}}, {4{Q_MAX}}));
		directed.push_back(mk(OP_PRODUCT, {4{Q_MIN}}, {4{Q_MIN}}));
		directed.push_back(mk(OP_PRODUCT, {Q_MAX, Q_MIN, Q_MAX, Q_MIN}, {Q_MIN, Q_MAX, Q_MAX, Q_MIN}));
		directed.push_back(mk(OP_PRODUCT, '0, r2));
		directed.push_back(mk(OP_PRODUCT, {4{32'hFFFF_FFFF}}, {4{32'h0000_0001}}));
		directed.push_back(mk(OP_PRODUCT, r1, r2));
		directed.push_back(mk(OP_ROTATE, {32'h0, 32'h0, 32'h0, Q_ONE}, {Q_ONE, -Q_ONE, Q_ONE, Q_MAX}));
		directed.push_back(mk(OP_ROTATE, {32'h0, 32'h0, Q_HALF, Q_HALF}, {Q_ONE, 32'h0, 32'h0, 32'h0}));
		directed.push_back(mk(OP_ROTATE, {4{Q_MAX}}, {4{Q_MAX}}));
		directed.push_back(mk(OP_ROTATE, {4{Q_MIN}}, {4{Q_MIN}}));
		directed.push_back(mk(OP_ROTATE, {Q_MIN, Q_MIN, Q_MIN, Q_ONE}, {Q_ONE, Q_ONE, Q_ONE, Q_MIN}));
		directed.push_back(mk(OP_ROTATE, r2, r1));
		directed.push_back(mk(OP_CONJ, {4{Q_MIN}}, r1));
		directed.push_back(mk(OP_CONJ, {4{Q_MAX}}, {4{Q_MIN}}));
		directed.push_back(mk(OP_CONJ, '0, '1));
		directed.push_back(mk(OP_CONJ, r1, r2));
		directed.push_back(mk(OP_NONE, r1, r2));
		directed.push_back(mk(OP_NONE, {4{Q_MAX}}, {4{Q_MIN}}));
		directed.push_back(mk(OP_NONE, '1, '1));
		foreach (directed[i])
			send_beat(directed[i], (i % 3 == 0) ? 0 : $urandom_range(0, 11));

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 500) begin
				rx_freeze = 300;
				tx_calm   = 60;
			end
			if (n == 1000) begin
				in_valid <= 1'b0;
				while (sb.expected_results.size() != 0)
					@(posedge clk);
			end
			send_beat(rand_request(), draw_gap());
		end
		in_valid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.fail_count++;

		if (sb.fail_count == 0)
			$display("quaternion_product_and_vector_rotate verification clean");
		else
			$display("quaternion_product_and_vector_rotate verification failed");
		$finish;
	end

endmodule

[quaternion_product_and_vector_rotate.f]
rtl/qvr_pkg.sv
rtl/qvr_qmul.sv
rtl/quaternion_product_and_vector_rotate.sv
tb/sv/tb_quaternion_product_and_vector_rotate.sv
